// File: hdl/bfc_pkg.sv
// Shared types and constants for the box frustum cull unit.
package bfc_pkg;

	localparam int VALUE_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int COEF_BITS      = 32;
	localparam int BOUND_BITS     = 32;
	localparam int AXES           = 3;
	localparam int ROWS           = 4;
	localparam int CORNERS        = 8;
	localparam int MAT_ENTRIES    = 16;

	typedef enum logic [1:0] {
		CMD_LOAD_PROJ = 2'd0,
		CMD_LOAD_MV   = 2'd1,
		CMD_COMPOSE   = 2'd2,
		CMD_BOX       = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t                          cmd;
		logic [3:0]                    coef_index;
		logic signed [COEF_BITS-1:0]   coef_value;
		logic signed [BOUND_BITS-1:0]  x_min;
		logic signed [BOUND_BITS-1:0]  x_max;
		logic signed [BOUND_BITS-1:0]  y_min;
		logic signed [BOUND_BITS-1:0]  y_max;
		logic signed [BOUND_BITS-1:0]  z_min;
		logic signed [BOUND_BITS-1:0]  z_max;
		logic                          bounds_valid;
		logic                          last_box;
	} in_beat_t;

	typedef struct packed {
		logic visible;
		logic seen_left;
		logic seen_right;
		logic seen_bottom;
		logic seen_top;
		logic seen_near;
		logic seen_far;
		logic last_out;
	} out_beat_t;

endpackage

// File: hdl/bfc_compose.sv
// Matrix store: coefficient loads and the projection x modelview compose sequencer.
module bfc_compose #(
	parameter int VALUE_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         take,
	input  bfc_pkg::in_beat_t            beat,
	output logic                         busy,
	output logic signed [VALUE_BITS-1:0] comb_m [bfc_pkg::MAT_ENTRIES]
);
	import bfc_pkg::*;

	localparam int PRODW = 2 * VALUE_BITS;
	localparam int SUMW  = 2 * VALUE_BITS + 3;
	localparam logic signed [63:0] MAX64 = {{(65-VALUE_BITS){1'b0}}, {(VALUE_BITS-1){1'b1}}};
	localparam logic signed [63:0] MIN64 = ~MAX64;
	localparam logic signed [SUMW-1:0] MAXS = {{(SUMW-VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
	localparam logic signed [SUMW-1:0] MINS = ~MAXS;
	localparam logic signed [SUMW-1:0] HALF = SUMW'(1) << (FRAC_BITS - 1);

	logic signed [VALUE_BITS-1:0] proj_q [MAT_ENTRIES];
	logic signed [VALUE_BITS-1:0] mv_q [MAT_ENTRIES];
	logic signed [VALUE_BITS-1:0] comb_q [MAT_ENTRIES];

	logic                         busy_q;
	logic [3:0]                   idx_q;
	logic                         av_s1;
	logic [3:0]                   aidx_s1;
	logic signed [PRODW-1:0]      prod_s1 [ROWS];

	logic                         start;
	logic signed [63:0]           cv64;
	logic signed [VALUE_BITS-1:0] ld_val;
	logic signed [SUMW-1:0]       acc;
	logic signed [SUMW-1:0]       shv;
	logic signed [VALUE_BITS-1:0] res;
	logic signed [VALUE_BITS-1:0] psel [ROWS];
	logic signed [VALUE_BITS-1:0] msel [ROWS];

	assign start = take && (beat.cmd == CMD_COMPOSE);
	assign busy  = busy_q || av_s1;
	assign comb_m = comb_q;

	// Saturate the 32-bit load value into the coefficient width.
	always_comb begin
		cv64 = 64'(beat.coef_value);
		if (cv64 > MAX64)
			ld_val = VALUE_BITS'(MAX64);
		else if (cv64 < MIN64)
			ld_val = VALUE_BITS'(MIN64);
		else
			ld_val = VALUE_BITS'(cv64);
	end

	// Element idx = c*4 + r takes row r of projection and column c of modelview.
	always_comb begin
		for (int k = 0; k < ROWS; k++) begin
			psel[k] = proj_q[{2'(k), idx_q[1:0]}];
			msel[k] = mv_q[{idx_q[3:2], 2'(k)}];
		end
	end

	always_comb begin
		acc = HALF;
		for (int k = 0; k < ROWS; k++)
			acc = acc + SUMW'(prod_s1[k]);
		shv = acc >>> FRAC_BITS;
		if (shv > MAXS)
			res = VALUE_BITS'(MAXS);
		else if (shv < MINS)
			res = VALUE_BITS'(MINS);
		else
			res = VALUE_BITS'(shv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
			av_s1  <= 1'b0;
		end else begin
			av_s1 <= busy_q;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				idx_q <= idx_q + 4'd1;
				if (idx_q == 4'hF)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		aidx_s1 <= idx_q;
		for (int k = 0; k < ROWS; k++)
			prod_s1[k] <= psel[k] * msel[k];
		if (take && beat.cmd == CMD_LOAD_PROJ)
			proj_q[beat.coef_index] <= ld_val;
		if (take && beat.cmd == CMD_LOAD_MV)
			mv_q[beat.coef_index] <= ld_val;
		if (av_s1)
			comb_q[aidx_s1] <= res;
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("compose started while busy");
	a_stage_follows: assert property (@(posedge clk) disable iff (!arst_n)
		av_s1 |-> $past(busy_q))
		else $error("product stage valid without issue");
	a_ends: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && idx_q == 4'hF |=> !busy_q && av_s1)
		else $error("compose did not end after last element");

endmodule

// File: hdl/bfc_box_pipe.sv
// Three-stage box test: products, corner coordinates, side compares.
module bfc_box_pipe #(
	parameter int VALUE_BITS = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_v,
	input  bfc_pkg::in_beat_t            beat,
	input  logic signed [VALUE_BITS-1:0] comb_m [bfc_pkg::MAT_ENTRIES],
	output logic                         out_v,
	output bfc_pkg::out_beat_t           out_data
);
	import bfc_pkg::*;

	localparam int PW = VALUE_BITS + BOUND_BITS;
	localparam int CW = VALUE_BITS + BOUND_BITS + 2;
	localparam int DW = CW + 1;

	logic signed [BOUND_BITS-1:0] lo [AXES];
	logic signed [BOUND_BITS-1:0] hi [AXES];

	logic                         v_s1, bv_s1, last_s1;
	logic signed [PW-1:0]         plo_s1 [AXES][ROWS];
	logic signed [PW-1:0]         phi_s1 [AXES][ROWS];
	logic signed [VALUE_BITS-1:0] t_s1 [ROWS];

	logic                         v_s2, bv_s2, last_s2;
	logic signed [CW-1:0]         c_s2 [CORNERS][ROWS];
	logic signed [CW-1:0]         cnext [CORNERS][ROWS];

	logic                         v_s3;
	out_beat_t                    o_s3;
	logic [5:0]                   flags;
	logic signed [DW-1:0]         dlt, dgt;

	assign lo[0] = beat.x_min;
	assign hi[0] = beat.x_max;
	assign lo[1] = beat.y_min;
	assign hi[1] = beat.y_max;
	assign lo[2] = beat.z_min;
	assign hi[2] = beat.z_max;

	// Corner i takes the upper x bound on bit 2, y on bit 1, z on bit 0.
	always_comb begin
		for (int i = 0; i < CORNERS; i++)
			for (int r = 0; r < ROWS; r++)
				cnext[i][r] = (CW'(t_s1[r]) <<< FRAC_BITS)
					+ CW'(i[2] ? phi_s1[0][r] : plo_s1[0][r])
					+ CW'(i[1] ? phi_s1[1][r] : plo_s1[1][r])
					+ CW'(i[0] ? phi_s1[2][r] : plo_s1[2][r]);
	end

	always_comb begin
		flags = '0;
		dlt = '0;
		dgt = '0;
		for (int i = 0; i < CORNERS; i++)
			for (int j = 0; j < AXES; j++) begin
				dlt = DW'(c_s2[i][j]) - DW'(c_s2[i][3]);
				dgt = DW'(c_s2[i][j]) + DW'(c_s2[i][3]);
				if (dlt < 0)
					flags[2*j] = 1'b1;
				if (dgt > 0)
					flags[2*j+1] = 1'b1;
			end
		if (!bv_s2)
			flags = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < AXES; k++)
				for (int r = 0; r < ROWS; r++) begin
					plo_s1[k][r] <= comb_m[k*4+r] * lo[k];
					phi_s1[k][r] <= comb_m[k*4+r] * hi[k];
				end
			for (int r = 0; r < ROWS; r++)
				t_s1[r] <= comb_m[12+r];
			bv_s1   <= beat.bounds_valid;
			last_s1 <= beat.last_box;

			c_s2    <= cnext;
			bv_s2   <= bv_s1;
			last_s2 <= last_s1;

			o_s3.visible     <= !bv_s2 || (&flags);
			o_s3.seen_left   <= flags[0];
			o_s3.seen_right  <= flags[1];
			o_s3.seen_bottom <= flags[2];
			o_s3.seen_top    <= flags[3];
			o_s3.seen_near   <= flags[4];
			o_s3.seen_far    <= flags[5];
			o_s3.last_out    <= last_s2;
		end
	end

	assign out_v    = v_s3;
	assign out_data = o_s3;

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s2 |=> v_s3)
		else $error("beat lost between stage two and output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s1) && $stable(v_s2))
		else $error("pipeline moved while stalled");
	a_vis: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && o_s3.seen_left && o_s3.seen_right && o_s3.seen_bottom && o_s3.seen_top
		&& o_s3.seen_near && o_s3.seen_far |-> o_s3.visible)
		else $error("all sides seen but box culled");

endmodule

// File: hdl/box_frustum_cull_unit.sv
// Top level of the box frustum cull unit: handshake, matrix store and box pipeline.
// Box beats pass product, corner and compare registers; one box accepted per cycle
// when the output is not stalled and no compose runs. Load beats give no result;
// a compose holds off input while the sequencer forms one combined coefficient per cycle.
// A stalled output freezes the whole box pipeline; nothing is dropped.
// Reset clears valid and sequencer state; matrices are undefined until written.
module box_frustum_cull_unit #(
	parameter int VALUE_BITS = bfc_pkg::VALUE_BITS_DEF,
	parameter int FRAC_BITS  = bfc_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bfc_pkg::in_beat_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output bfc_pkg::out_beat_t out_data
);
	import bfc_pkg::*;

	logic                         en;
	logic                         take;
	logic                         busy;
	logic signed [VALUE_BITS-1:0] comb_m [MAT_ENTRIES];

	assign en       = !out_valid || out_ready;
	assign in_ready = en && !busy;
	assign take     = in_valid && in_ready;

	bfc_compose #(
		.VALUE_BITS(VALUE_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_compose (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take),
		.beat  (in_data),
		.busy  (busy),
		.comb_m(comb_m)
	);

	bfc_box_pipe #(
		.VALUE_BITS(VALUE_BITS),
		.FRAC_BITS (FRAC_BITS)
	) u_box (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (take && in_data.cmd == CMD_BOX),
		.beat    (in_data),
		.comb_m  (comb_m),
		.out_v   (out_valid),
		.out_data(out_data)
	);

endmodule
